>>> design/sv39ptw_pkg.sv
`default_nettype none
package sv39ptw_pkg;

  localparam int TABLE_PAGES_DEF = 16;
  localparam int MAX_RUN_DEF     = 64;

  // request codes
  localparam logic [2:0] REQ_WRITE   = 3'd0;
  localparam logic [2:0] REQ_READ    = 3'd1;
  localparam logic [2:0] REQ_XLATE   = 3'd2;
  localparam logic [2:0] REQ_MAP     = 3'd3;
  localparam logic [2:0] REQ_UNMAP   = 3'd4;

  // status codes
  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_UNMAPPED = 3'd1;
  localparam logic [2:0] ST_VA       = 3'd2;
  localparam logic [2:0] ST_NOTABLE  = 3'd3;
  localparam logic [2:0] ST_REMAP    = 3'd4;
  localparam logic [2:0] ST_NOTLEAF  = 3'd5;
  localparam logic [2:0] ST_OUTSIDE  = 3'd6;

  // config register indexes
  localparam logic [1:0] CFG_BASE    = 2'd0;
  localparam logic [1:0] CFG_ROOT    = 2'd1;
  localparam logic [1:0] CFG_FFREE   = 2'd2;

  localparam int ENTRY_BITS = 9;
  localparam int PPN_W      = 44;

endpackage
`default_nettype wire

>>> design/sv39_page_table_walker.sv
`default_nettype none
// Channel  | direction | handshake          | payload
// cfg      | in        | cfg_we             | cfg_index, cfg_data
// request  | in        | in_valid/in_stall  | req_type .. pte_value
// result   | out       | out_valid/out_stall| status, result_addr, free_valid, read_data, last
//
// Sequence: a raw write goes straight to its result; a raw read adds a capture
// state. Translate: a setup state, three table reads, one result state. Map/unmap
// walk page by page, with a free result for a page that frees; a final result
// follows unless an unmap emitted frees. Each table page allocation adds a clear
// sweep of its 512 entries and a link write. Reset: after rst the store is swept
// to zero, TABLE_PAGES*512 entries, with in_stall held high. Config writes are
// taken at any time. Stalls: a finished result sits in the output register; the
// walker waits only when it needs to place another result there.
module sv39_page_table_walker
  import sv39ptw_pkg::*;
#(
  parameter int TABLE_PAGES = TABLE_PAGES_DEF,
  parameter int MAX_RUN     = MAX_RUN_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [43:0] cfg_data,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [2:0]  req_type,
  input  wire logic [38:0] virt_addr,
  input  wire logic [55:0] phys_addr,
  input  wire logic [7:0]  perm,
  input  wire logic [6:0]  page_count,
  input  wire logic        do_free,
  input  wire logic [3:0]  table_page,
  input  wire logic [8:0]  entry_index,
  input  wire logic [63:0] pte_value,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [2:0]       status,
  output logic [55:0]      result_addr,
  output logic             free_valid,
  output logic [63:0]      read_data,
  output logic             last
);

  localparam int PIW   = (TABLE_PAGES > 1) ? $clog2(TABLE_PAGES) : 1;
  localparam int AW    = PIW + ENTRY_BITS;
  localparam int DEPTH = TABLE_PAGES * 512;

  localparam logic [3:0] S_CLEAR     = 4'd0;
  localparam logic [3:0] S_IDLE      = 4'd1;
  localparam logic [3:0] S_RAWRD     = 4'd2;
  localparam logic [3:0] S_PAGE      = 4'd3;
  localparam logic [3:0] S_READ      = 4'd4;
  localparam logic [3:0] S_EVAL      = 4'd5;
  localparam logic [3:0] S_ALLOC_CLR = 4'd6;
  localparam logic [3:0] S_ALLOC_WR  = 4'd7;
  localparam logic [3:0] S_NEXT      = 4'd8;
  localparam logic [3:0] S_EMIT      = 4'd9;

  // table store, one write port and one read port
  logic [63:0] store [DEPTH];
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [63:0]   mem_wdata;
  logic [AW-1:0] mem_raddr;
  logic [63:0]   rdata;

  always_ff @(posedge clk) begin
    if (mem_we) store[mem_waddr] <= mem_wdata;
    rdata <= store[mem_raddr];
  end

  // config
  logic [43:0] tbase;
  logic [3:0]  root_pg;
  logic [3:0]  ffree;

  always_ff @(posedge clk) begin
    if (rst) begin
      tbase   <= '0;
      root_pg <= '0;
      ffree   <= 4'd1;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_BASE:  tbase   <= cfg_data;
        CFG_ROOT:  root_pg <= cfg_data[3:0];
        CFG_FFREE: ffree   <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  // sequencer state
  logic [3:0]     state;
  logic [AW-1:0]  clr_cnt;
  logic [8:0]     clr_idx;
  logic [4:0]     palloc;
  logic [2:0]     req;
  logic [27:0]    vpn;
  logic [43:0]    ppage;
  logic [7:0]     perm_r;
  logic [6:0]     cnt;
  logic [6:0]     pg_i;
  logic           free_r;
  logic           any_free;
  logic [1:0]     level;
  logic [PIW-1:0] page;
  logic [PIW-1:0] np_page;
  logic [AW-1:0]  ent_addr;
  logic [3:0]     ret;
  logic [2:0]     stg_status;
  logic [55:0]    stg_addr;
  logic           stg_free;
  logic [63:0]    stg_data;
  logic           stg_last;

  logic [8:0]  lvl_idx;
  logic [43:0] pdiff;
  logic [5:0]  np;
  logic        np_bad;
  logic        out_free;
  logic        raw_bad;
  logic [AW-1:0] raw_addr;
  logic [6:0]  cnt_sat;
  logic [55:0] leaf_pa;

  always_comb begin
    case (level)
      2'd2:    lvl_idx = vpn[26:18];
      2'd1:    lvl_idx = vpn[17:9];
      default: lvl_idx = vpn[8:0];
    endcase
  end

  assign pdiff    = rdata[53:10] - tbase;
  assign np       = {2'b00, ffree} + {1'b0, palloc};
  assign np_bad   = (palloc == 5'd31) || (32'(np) >= TABLE_PAGES);
  assign out_free = !out_valid || !out_stall;
  assign raw_bad  = 32'(table_page) >= TABLE_PAGES;
  assign raw_addr = {PIW'(table_page), entry_index};
  assign cnt_sat  = (32'(page_count) > MAX_RUN) ? 7'(MAX_RUN) : page_count;
  assign leaf_pa  = {rdata[53:10], 12'h000};
  assign in_stall = (state != S_IDLE);

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = {page, lvl_idx};
    mem_wdata = '0;
    mem_raddr = (state == S_IDLE) ? raw_addr : {page, lvl_idx};
    case (state)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_cnt;
      end
      S_IDLE: begin
        mem_we    = in_valid && (req_type == REQ_WRITE) && !raw_bad;
        mem_waddr = raw_addr;
        mem_wdata = pte_value;
      end
      S_ALLOC_CLR: begin
        mem_we    = 1'b1;
        mem_waddr = {np_page, clr_idx};
      end
      S_ALLOC_WR: begin
        mem_we    = 1'b1;
        mem_waddr = ent_addr;
        mem_wdata = {10'b0, tbase + 44'(np_page), 10'h001};
      end
      S_EVAL: begin
        if (level == 2'd0) begin
          if (req == REQ_MAP && !rdata[0]) begin
            mem_we    = 1'b1;
            mem_wdata = {10'b0, ppage, 2'b00, perm_r | 8'h01};
          end else if (req == REQ_UNMAP && rdata[0] && rdata[9:0] != 10'h001) begin
            mem_we    = 1'b1;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_cnt   <= '0;
      palloc    <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && !out_stall && state != S_EMIT) out_valid <= 1'b0;
      case (state)
        S_CLEAR: begin
          clr_cnt <= clr_cnt + 1'b1;
          if (clr_cnt == AW'(DEPTH - 1)) state <= S_IDLE;
        end
        S_IDLE: begin
          if (in_valid) begin
            req      <= req_type;
            vpn      <= {1'b0, virt_addr[38:12]};
            ppage    <= phys_addr[55:12];
            perm_r   <= perm;
            cnt      <= cnt_sat;
            free_r   <= do_free;
            pg_i     <= '0;
            any_free <= 1'b0;
            stg_addr <= '0;
            stg_free <= 1'b0;
            stg_data <= '0;
            stg_last <= 1'b1;
            ret      <= S_IDLE;
            case (req_type)
              REQ_WRITE, REQ_READ: begin
                if (raw_bad) begin
                  stg_status <= ST_OUTSIDE;
                  state      <= S_EMIT;
                end else begin
                  stg_status <= ST_OK;
                  state      <= (req_type == REQ_READ) ? S_RAWRD : S_EMIT;
                end
              end
              REQ_XLATE: state <= S_PAGE;
              REQ_MAP, REQ_UNMAP: begin
                if (cnt_sat == 7'd0) begin
                  stg_status <= ST_OK;
                  state      <= S_EMIT;
                end else begin
                  state <= S_PAGE;
                end
              end
              default: ;
            endcase
          end
        end
        S_RAWRD: begin
          stg_data <= rdata;
          state    <= S_EMIT;
        end
        S_PAGE: begin
          page     <= PIW'(root_pg);
          level    <= 2'd2;
          stg_addr <= '0;
          stg_free <= 1'b0;
          if (vpn[27:26] != 2'b00) begin
            stg_status <= ST_VA;
            ret        <= S_IDLE;
            stg_last   <= 1'b1;
            state      <= S_EMIT;
          end else if (32'(root_pg) >= TABLE_PAGES) begin
            stg_status <= ST_OUTSIDE;
            ret        <= S_IDLE;
            stg_last   <= 1'b1;
            state      <= S_EMIT;
          end else begin
            state <= S_READ;
          end
        end
        S_READ: state <= S_EVAL;
        S_EVAL: begin
          stg_addr <= '0;
          stg_free <= 1'b0;
          stg_last <= 1'b1;
          ret      <= S_IDLE;
          if (level != 2'd0) begin
            if (rdata[0]) begin
              if (pdiff >= 44'(TABLE_PAGES)) begin
                stg_status <= ST_OUTSIDE;
                state      <= S_EMIT;
              end else begin
                page  <= PIW'(pdiff);
                level <= level - 1'b1;
                state <= S_READ;
              end
            end else if (req != REQ_MAP) begin
              stg_status <= ST_UNMAPPED;
              state      <= S_EMIT;
            end else if (np_bad) begin
              stg_status <= ST_NOTABLE;
              state      <= S_EMIT;
            end else begin
              np_page  <= PIW'(np);
              ent_addr <= {page, lvl_idx};
              clr_idx  <= '0;
              state    <= S_ALLOC_CLR;
            end
          end else begin
            case (req)
              REQ_XLATE: begin
                if (rdata[0] && rdata[4]) begin
                  stg_status <= ST_OK;
                  stg_addr   <= leaf_pa;
                end else begin
                  stg_status <= ST_UNMAPPED;
                end
                state <= S_EMIT;
              end
              REQ_MAP: begin
                if (rdata[0]) begin
                  stg_status <= ST_REMAP;
                  state      <= S_EMIT;
                end else begin
                  state <= S_NEXT;
                end
              end
              default: begin
                if (!rdata[0]) begin
                  stg_status <= ST_UNMAPPED;
                  state      <= S_EMIT;
                end else if (rdata[9:0] == 10'h001) begin
                  stg_status <= ST_NOTLEAF;
                  state      <= S_EMIT;
                end else if (free_r) begin
                  // free result; last only when this is the final page
                  stg_status <= ST_OK;
                  stg_addr   <= leaf_pa;
                  stg_free   <= 1'b1;
                  stg_last   <= (pg_i + 1'b1 == cnt);
                  any_free   <= 1'b1;
                  ret        <= S_NEXT;
                  state      <= S_EMIT;
                end else begin
                  state <= S_NEXT;
                end
              end
            endcase
          end
        end
        S_ALLOC_CLR: begin
          clr_idx <= clr_idx + 1'b1;
          if (clr_idx == 9'h1FF) state <= S_ALLOC_WR;
        end
        S_ALLOC_WR: begin
          palloc <= palloc + 1'b1;
          page   <= np_page;
          level  <= level - 1'b1;
          state  <= S_READ;
        end
        S_NEXT: begin
          pg_i  <= pg_i + 1'b1;
          vpn   <= vpn + 1'b1;
          ppage <= ppage + 1'b1;
          if (pg_i + 1'b1 == cnt) begin
            stg_status <= ST_OK;
            stg_addr   <= '0;
            stg_free   <= 1'b0;
            stg_last   <= 1'b1;
            ret        <= S_IDLE;
            state      <= (req == REQ_UNMAP && any_free) ? S_IDLE : S_EMIT;
          end else begin
            state <= S_PAGE;
          end
        end
        S_EMIT: begin
          if (out_free) begin
            out_valid   <= 1'b1;
            status      <= stg_status;
            result_addr <= stg_addr;
            free_valid  <= stg_free;
            read_data   <= stg_data;
            last        <= stg_last;
            state       <= ret;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTH
  a_clear_stall: assert property (@(posedge clk) disable iff (rst)
    (state == S_CLEAR) |-> in_stall) else $error("request taken during store clear");
  a_free_ok: assert property (@(posedge clk) disable iff (rst)
    (out_valid && free_valid) |-> (status == ST_OK)) else $error("free with error status");
  a_err_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status != ST_OK) |-> last) else $error("error result not last");
  a_palloc: assert property (@(posedge clk) disable iff (rst)
    (state == S_ALLOC_WR) |-> (palloc != 5'd31)) else $error("allocator overrun");
`endif

endmodule
`default_nettype wire
